### sv/fwdrm_pkg.sv
// Shared types, constants and the motion sign table for the four-wheel ramp mixer.
// Depends on nothing; every other file of the block imports it.
package fwdrm_pkg;

    localparam int NUM_WHEELS = 4;
    localparam int SPEED_W    = 11;
    localparam int MAG_W      = 10;
    localparam int CFG_IDX_W  = 3;

    typedef logic signed [SPEED_W-1:0] speed_t;
    typedef logic [MAG_W-1:0]          mag_t;
    typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;
    typedef logic [3:0]                cmd_code_t;

    // Register indexes of the configuration port.
    localparam cfg_idx_t REG_STRAIGHT = 3'd0;
    localparam cfg_idx_t REG_DIAGONAL = 3'd1;
    localparam cfg_idx_t REG_TURN     = 3'd2;
    localparam cfg_idx_t REG_RAMP     = 3'd3;

    localparam mag_t STRAIGHT_RESET = 10'd100;
    localparam mag_t DIAGONAL_RESET = 10'd100;
    localparam mag_t TURN_RESET     = 10'd100;
    localparam mag_t RAMP_RESET     = 10'd5;

    typedef enum logic [3:0] {
        CMD_STOP       = 4'd0,
        CMD_FWD        = 4'd1,
        CMD_BACK       = 4'd2,
        CMD_LEFT       = 4'd3,
        CMD_RIGHT      = 4'd4,
        CMD_FWD_LEFT   = 4'd5,
        CMD_FWD_RIGHT  = 4'd6,
        CMD_BACK_LEFT  = 4'd7,
        CMD_BACK_RIGHT = 4'd8,
        CMD_SPIN_LEFT  = 4'd9,
        CMD_SPIN_RIGHT = 4'd10
    } cmd_e;

    typedef enum logic [1:0] {
        SEL_STRAIGHT = 2'd0,
        SEL_DIAGONAL = 2'd1,
        SEL_TURN     = 2'd2,
        SEL_NONE     = 2'd3
    } mag_sel_e;

    typedef enum logic [1:0] {
        SGN_ZERO = 2'd0,
        SGN_POS  = 2'd1,
        SGN_NEG  = 2'd2
    } sgn_e;

    // Control strobes passed from the top level to the state modules.
    typedef struct packed {
        logic cmd_load;
        logic tick;
    } fwdrm_ctrl_t;

    // Which speed register sets the magnitude of a move.
    function automatic mag_sel_e move_mag_sel(input cmd_code_t code);
        mag_sel_e sel;
        unique case (code)
            CMD_FWD, CMD_BACK, CMD_LEFT, CMD_RIGHT:
                sel = SEL_STRAIGHT;
            CMD_FWD_LEFT, CMD_FWD_RIGHT, CMD_BACK_LEFT, CMD_BACK_RIGHT:
                sel = SEL_DIAGONAL;
            CMD_SPIN_LEFT, CMD_SPIN_RIGHT:
                sel = SEL_TURN;
            default:
                sel = SEL_NONE;
        endcase
        return sel;
    endfunction

    // Direction of one wheel for a move; unknown codes stop every wheel.
    function automatic sgn_e move_sign(input cmd_code_t code, input logic [1:0] wheel);
        sgn_e row [NUM_WHEELS];
        unique case (code)
            CMD_FWD:        row = '{SGN_NEG,  SGN_POS,  SGN_POS,  SGN_NEG};
            CMD_BACK:       row = '{SGN_POS,  SGN_NEG,  SGN_NEG,  SGN_POS};
            CMD_LEFT:       row = '{SGN_POS,  SGN_POS,  SGN_POS,  SGN_POS};
            CMD_RIGHT:      row = '{SGN_NEG,  SGN_NEG,  SGN_NEG,  SGN_NEG};
            CMD_FWD_LEFT:   row = '{SGN_ZERO, SGN_POS,  SGN_POS,  SGN_ZERO};
            CMD_FWD_RIGHT:  row = '{SGN_NEG,  SGN_ZERO, SGN_ZERO, SGN_NEG};
            CMD_BACK_LEFT:  row = '{SGN_POS,  SGN_ZERO, SGN_ZERO, SGN_POS};
            CMD_BACK_RIGHT: row = '{SGN_ZERO, SGN_NEG,  SGN_NEG,  SGN_ZERO};
            CMD_SPIN_LEFT:  row = '{SGN_POS,  SGN_NEG,  SGN_POS,  SGN_NEG};
            CMD_SPIN_RIGHT: row = '{SGN_NEG,  SGN_POS,  SGN_NEG,  SGN_POS};
            default:        row = '{SGN_ZERO, SGN_ZERO, SGN_ZERO, SGN_ZERO};
        endcase
        return row[wheel];
    endfunction

endpackage

### sv/fwdrm_targets.sv
// Target speed registers: decodes a motion command into four signed wheel targets.
// Depends on fwdrm_pkg for the sign table, speed types and control strobes.
module fwdrm_targets (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fwdrm_pkg::fwdrm_ctrl_t ctrl,
    input  fwdrm_pkg::cmd_code_t command_code,
    input  fwdrm_pkg::mag_t      straight_speed,
    input  fwdrm_pkg::mag_t      diagonal_speed,
    input  fwdrm_pkg::mag_t      turn_speed,
    output fwdrm_pkg::speed_t    targets [fwdrm_pkg::NUM_WHEELS]
);
    import fwdrm_pkg::*;

    mag_t   mag;
    speed_t mag_ext;
    speed_t target_reg  [NUM_WHEELS];
    speed_t target_next [NUM_WHEELS];

    always_comb
    begin
        unique case (move_mag_sel(command_code))
            SEL_STRAIGHT: mag = straight_speed;
            SEL_DIAGONAL: mag = diagonal_speed;
            SEL_TURN:     mag = turn_speed;
            SEL_NONE:     mag = '0;
        endcase
        mag_ext = speed_t'({1'b0, mag});
    end

    for (genvar w = 0; w < NUM_WHEELS; w++)
    begin : g_wheel
        always_comb
        begin
            unique case (move_sign(command_code, 2'(w)))
                SGN_POS: target_next[w] = mag_ext;
                SGN_NEG: target_next[w] = -mag_ext;
                default: target_next[w] = '0;
            endcase
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                target_reg[w] <= '0;
            end
            else if (ctrl.cmd_load)
            begin
                target_reg[w] <= target_next[w];
            end
        end

        assign targets[w] = target_reg[w];
    end

endmodule

### sv/fwdrm_ramp.sv
// Current speed registers: on each tick every wheel steps toward its target, clamped.
// Depends on fwdrm_pkg for the speed types and control strobes.
module fwdrm_ramp (
    input  logic                   clk,
    input  logic                   rst_n,
    input  fwdrm_pkg::fwdrm_ctrl_t ctrl,
    input  fwdrm_pkg::mag_t        step_size,
    input  fwdrm_pkg::speed_t      targets [fwdrm_pkg::NUM_WHEELS],
    output fwdrm_pkg::speed_t      speeds  [fwdrm_pkg::NUM_WHEELS]
);
    import fwdrm_pkg::*;

    speed_t current_reg  [NUM_WHEELS];
    speed_t current_next [NUM_WHEELS];

    for (genvar w = 0; w < NUM_WHEELS; w++)
    begin : g_wheel
        logic signed [SPEED_W:0] cur_x;
        logic signed [SPEED_W:0] tgt_x;
        logic signed [SPEED_W:0] step_x;
        logic signed [SPEED_W:0] up;
        logic signed [SPEED_W:0] dn;

        always_comb
        begin
            cur_x  = {current_reg[w][SPEED_W-1], current_reg[w]};
            tgt_x  = {targets[w][SPEED_W-1], targets[w]};
            step_x = {2'b00, step_size};
            up     = cur_x + step_x;
            dn     = cur_x - step_x;
            if (cur_x < tgt_x)
            begin
                current_next[w] = (up > tgt_x) ? targets[w] : up[SPEED_W-1:0];
            end
            else if (cur_x > tgt_x)
            begin
                current_next[w] = (dn < tgt_x) ? targets[w] : dn[SPEED_W-1:0];
            end
            else
            begin
                current_next[w] = current_reg[w];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                current_reg[w] <= '0;
            end
            else if (ctrl.tick)
            begin
                current_reg[w] <= current_next[w];
            end
        end

        assign speeds[w] = current_reg[w];
    end

endmodule

### sv/four_wheel_drive_ramp_mixer_unit.sv
// Four-wheel ramp mixer, top level: handshakes, input register, configuration registers.
// Depends on fwdrm_pkg, fwdrm_targets and fwdrm_ramp.
//
// The block takes one request per input transfer. A motion command (req_type 0)
// looks up a sign for each of the four wheels and scales it by the straight,
// diagonal or turn speed register as they stand when the command is processed;
// codes 11 to 15 act as stop. A command produces no output transfer. A ramp tick
// (req_type 1) moves each wheel's current speed toward its target by at most
// the step size register, landing exactly on the target, and then presents the
// four current speeds as one output transfer. Requests are taken at one per clock
// cycle while no tick waits behind an untaken result: a transfer lands in the input
// register, and when it leaves, the command decode or the ramp step writes the target
// or current speed registers. The current speed registers double as the result
// register; while a result waits to be taken, commands keep flowing and only a
// further tick waits, so the sole limit on throughput is the consumer's ready.
// Configuration writes take effect at once, should only be made while no request
// is in flight, and writes to indexes above 3 are ignored.
module four_wheel_drive_ramp_mixer_unit (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   req_type,
    input  fwdrm_pkg::cmd_code_t   command_code,
    output logic                   out_valid,
    input  logic                   out_ready,
    output fwdrm_pkg::speed_t      wheel0_speed,
    output fwdrm_pkg::speed_t      wheel1_speed,
    output fwdrm_pkg::speed_t      wheel2_speed,
    output fwdrm_pkg::speed_t      wheel3_speed,
    input  logic                   cfg_we,
    input  fwdrm_pkg::cfg_idx_t    cfg_index,
    input  fwdrm_pkg::mag_t        cfg_data
);
    import fwdrm_pkg::*;

    // Configuration registers.
    mag_t straight_reg;
    mag_t diagonal_reg;
    mag_t turn_reg;
    mag_t ramp_reg;

    // Input register holding one accepted request.
    logic      s1_valid_reg;
    logic      s1_tick_reg;
    cmd_code_t s1_code_reg;

    logic        out_valid_reg;
    logic        s1_go;
    logic        in_fire;
    fwdrm_ctrl_t ctrl;

    speed_t targets [NUM_WHEELS];
    speed_t speeds  [NUM_WHEELS];

    // A command can always leave the input register; a tick needs the result
    // register to be empty or being emptied in this cycle.
    assign s1_go    = s1_valid_reg && (!s1_tick_reg || !out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_go;
    assign in_fire  = in_valid && in_ready;

    assign ctrl.cmd_load = s1_go && !s1_tick_reg;
    assign ctrl.tick     = s1_go && s1_tick_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            straight_reg <= STRAIGHT_RESET;
            diagonal_reg <= DIAGONAL_RESET;
            turn_reg     <= TURN_RESET;
            ramp_reg     <= RAMP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_STRAIGHT: straight_reg <= cfg_data;
                REG_DIAGONAL: diagonal_reg <= cfg_data;
                REG_TURN:     turn_reg     <= cfg_data;
                REG_RAMP:     ramp_reg     <= cfg_data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Payload of the input register needs no reset.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_tick_reg <= req_type;
            s1_code_reg <= command_code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.tick)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    fwdrm_targets u_targets (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .command_code   (s1_code_reg),
        .straight_speed (straight_reg),
        .diagonal_speed (diagonal_reg),
        .turn_speed     (turn_reg),
        .targets        (targets)
    );

    fwdrm_ramp u_ramp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .step_size (ramp_reg),
        .targets   (targets),
        .speeds    (speeds)
    );

    assign out_valid    = out_valid_reg;
    assign wheel0_speed = speeds[0];
    assign wheel1_speed = speeds[1];
    assign wheel2_speed = speeds[2];
    assign wheel3_speed = speeds[3];

endmodule

### sv/fwdrm_checker.sv
// Port-level checker for the four-wheel ramp mixer and its bind to the top level.
// Depends on fwdrm_pkg for the port types.
module fwdrm_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 req_type,
    input logic                 out_valid,
    input logic                 out_ready,
    input fwdrm_pkg::speed_t    wheel0_speed,
    input fwdrm_pkg::speed_t    wheel1_speed,
    input fwdrm_pkg::speed_t    wheel2_speed,
    input fwdrm_pkg::speed_t    wheel3_speed
);
    import fwdrm_pkg::*;

    // A held result keeps its speeds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(wheel0_speed)
            && $stable(wheel1_speed) && $stable(wheel2_speed) && $stable(wheel3_speed))
        else $error("held result changed");

    // The input side only stalls behind a result that is not being taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output back-pressure");

    // A fresh result always follows an accepted tick transfer through the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready && req_type, 2))
        else $error("result appeared without a tick");

    // Speeds stay inside the symmetric range; the most negative code never shows.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> wheel0_speed != 11'h400 && wheel1_speed != 11'h400
            && wheel2_speed != 11'h400 && wheel3_speed != 11'h400)
        else $error("wheel speed out of range");

endmodule

bind four_wheel_drive_ramp_mixer_unit fwdrm_checker u_fwdrm_checker (.*);
